/* sv/pshm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pshm_pkg
// Shared constants and controller/datapath interface types for the
// polynomial string hash.
// ----------------------------------------------------------------------------
package pshm_pkg;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 1;
	localparam int BYTE_W      = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MULTIPLIER = 1'd1;

	localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET   = 32'd1024;
	localparam logic [CFG_DATA_W-1:0] MULTIPLIER_RESET = 32'd31;

	// controller -> datapath
	typedef struct packed {
		logic take;        // input beat accepted, latch the byte
		logic load_mul;    // multiply-accumulate, load remainder unit
		logic load_fin;    // load hash*2+1 into remainder unit
		logic step;        // one restoring remainder step
		logic write_hash;  // store remainder as running hash
		logic emit;        // present remainder as bucket, clear hash
	} pshm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_busy;    // output register holds a beat that is not taken
	} pshm_status_t;

endpackage
`default_nettype wire

/* sv/pshm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pshm_datapath
// Config registers, running hash, multiply-accumulate, bit-serial restoring
// remainder unit and output register.
// ----------------------------------------------------------------------------
module pshm_datapath #(
	parameter int HASH_BITS = 31
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [pshm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [pshm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [pshm_pkg::BYTE_W-1:0]       key_byte,
	input  wire pshm_pkg::pshm_cmd_t               cmd,
	output      pshm_pkg::pshm_status_t            sts,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [HASH_BITS-1:0]              bucket
);
	import pshm_pkg::*;

	localparam int P_W   = HASH_BITS + CFG_DATA_W;  // product width
	localparam int SHAMT = P_W - HASH_BITS - 1;     // aligns finish dividend to top
	localparam logic [CFG_DATA_W-1:0] CAP_TOP = CFG_DATA_W'(1) << HASH_BITS;

	logic [CFG_DATA_W-1:0] capacity_q;
	logic [CFG_DATA_W-1:0] multiplier_q;
	logic [HASH_BITS-1:0]  hash_q;
	logic [BYTE_W-1:0]     byte_q;
	logic [P_W-1:0]        div_q;
	logic [HASH_BITS-1:0]  rem_q;
	logic [HASH_BITS:0]    cap_eff_q;
	logic [HASH_BITS-1:0]  bucket_q;
	logic                  out_valid_q;

	logic [CFG_DATA_W-1:0] cap_sel;
	logic [HASH_BITS:0]    cap_eff;
	logic [P_W-1:0]        prod;
	logic [P_W-1:0]        fin_div;
	logic [HASH_BITS:0]    rem_sh;
	logic [HASH_BITS:0]    rem_diff;
	logic [HASH_BITS-1:0]  rem_next;

	// zero capacity acts as one, oversize saturates to 2^HASH_BITS
	always_comb begin
		if (capacity_q == '0) begin
			cap_sel = CFG_DATA_W'(1);
		end else if (capacity_q > CAP_TOP) begin
			cap_sel = CAP_TOP;
		end else begin
			cap_sel = capacity_q;
		end
	end
	assign cap_eff = cap_sel[HASH_BITS:0];

	assign prod    = P_W'(hash_q) * P_W'(multiplier_q) + P_W'(byte_q);
	assign fin_div = P_W'({hash_q, 1'b1}) << SHAMT;

	// rem_q < cap_eff_q, so the shifted value is below 2*cap_eff_q
	assign rem_sh   = {rem_q, div_q[P_W-1]};
	assign rem_diff = rem_sh - cap_eff_q;
	assign rem_next = (rem_sh >= cap_eff_q) ? rem_diff[HASH_BITS-1:0] : rem_sh[HASH_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAPACITY_RESET;
			multiplier_q <= MULTIPLIER_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CAPACITY:   capacity_q   <= cfg_data;
				REG_MULTIPLIER: multiplier_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (cmd.emit) begin
			hash_q <= '0;
		end else if (cmd.write_hash) begin
			hash_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= key_byte;
		end
		if (cmd.load_mul) begin
			div_q     <= prod;
			rem_q     <= '0;
			cap_eff_q <= cap_eff;
		end else if (cmd.load_fin) begin
			div_q     <= fin_div;
			rem_q     <= '0;
			cap_eff_q <= cap_eff;
		end else if (cmd.step) begin
			div_q <= div_q << 1;
			rem_q <= rem_next;
		end
		if (cmd.emit) begin
			bucket_q <= rem_q;
		end
	end

	assign sts.out_busy = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign bucket       = bucket_q;

	a_rem_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> ({1'b0, rem_q} < cap_eff_q))
		else $error("remainder not below modulus during reduction");

	a_emit_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q && (hash_q == '0) && ({1'b0, bucket_q} < cap_eff_q))
		else $error("emitted bucket out of range or hash not cleared");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && out_stall))
		else $error("bucket overwritten while stalled");

endmodule
`default_nettype wire

/* sv/pshm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pshm_ctrl
// Sequencer: accept a beat, multiply-accumulate, run the remainder steps,
// apply the finish step and hand the bucket to the output register.
// ----------------------------------------------------------------------------
module pshm_ctrl #(
	parameter int HASH_BITS = 31
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output      logic                    in_stall,
	input  wire logic                    has_byte,
	input  wire logic                    last_byte,
	input  wire pshm_pkg::pshm_status_t  sts,
	output      pshm_pkg::pshm_cmd_t     cmd
);
	import pshm_pkg::*;

	localparam int P_W   = HASH_BITS + CFG_DATA_W;
	localparam int CNT_W = $clog2(P_W + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             fin_q, fin_d;
	logic             last_q, last_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		fin_d   = fin_q;
		last_d  = last_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					last_d   = last_byte;
					if (has_byte) begin
						state_d = ST_MUL;
					end else if (last_byte) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_MUL: begin
				cmd.load_mul = 1'b1;
				cnt_d        = CNT_W'(P_W);
				fin_d        = 1'b0;
				state_d      = ST_DIV;
			end
			ST_FIN: begin
				cmd.load_fin = 1'b1;
				cnt_d        = CNT_W'(HASH_BITS + 1);
				fin_d        = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					if (fin_q) begin
						state_d = ST_EMIT;
					end else begin
						cmd.write_hash = 1'b1;
						state_d        = last_q ? ST_FIN : ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
			last_q  <= last_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q != '0))
		else $error("reduction running with exhausted step count");

	a_fin_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_hash && last_q |=> (state_q == ST_FIN))
		else $error("last beat did not go on to the finish step");

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_mul, cmd.load_fin, cmd.step, cmd.emit}))
		else $error("conflicting datapath commands");

endmodule
`default_nettype wire

/* sv/polynomial_string_hash_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_string_hash_mod
// Polynomial string hash of a byte-serial key, reduced modulo a table size.
// ----------------------------------------------------------------------------
// Each beat with a byte folds it in as (hash*multiplier + byte) mod capacity;
// a beat marked last then applies (hash*2+1) mod capacity, emits the bucket
// and clears the hash. One beat is worked on at a time. A byte beat is
// accepted, then multiply-accumulated, then reduced one remainder bit per
// cycle over the HASH_BITS+32 bit product in the restoring reduction unit.
// The last beat adds the finish step through the same unit, plus a hand-off
// to the output register, which waits while the output is still stalled.
// A beat with neither byte nor last is taken and changes nothing.
// Capacity zero acts as one; capacity above 2^HASH_BITS saturates to it.
// The user must write registers only between keys' beats, while nothing
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module polynomial_string_hash_mod #(
	parameter int HASH_BITS = 31
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [pshm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [pshm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic [pshm_pkg::BYTE_W-1:0]       key_byte,
	input  wire logic                              has_byte,
	input  wire logic                              last_byte,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [HASH_BITS-1:0]              bucket
);
	import pshm_pkg::*;

	pshm_cmd_t    cmd;
	pshm_status_t sts;

	pshm_ctrl #(
		.HASH_BITS (HASH_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.has_byte  (has_byte),
		.last_byte (last_byte),
		.sts       (sts),
		.cmd       (cmd)
	);

	pshm_datapath #(
		.HASH_BITS (HASH_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key_byte  (key_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bucket    (bucket)
	);

endmodule
`default_nettype wire

/* test/polynomial_string_hash_mod_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_string_hash_mod_check
// Watches the register port and both beat channels of the string hash,
// keeps its own copy of the registers and running hash, and compares every
// bucket that leaves the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module polynomial_string_hash_mod_check #(
	parameter int HASH_BITS = 31
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [pshm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pshm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [pshm_pkg::BYTE_W-1:0]      key_byte,
	input  logic                             has_byte,
	input  logic                             last_byte,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [HASH_BITS-1:0]             bucket,
	output int                               errors,
	output int                               outstanding,
	output int                               buckets_seen
);
	import pshm_pkg::*;

	logic [CFG_DATA_W-1:0] capacity_reg;
	logic [CFG_DATA_W-1:0] multiplier_reg;
	logic [63:0]           hash_acc;
	logic [HASH_BITS-1:0]  bucket_q[$];

	initial begin
		errors       = 0;
		outstanding  = 0;
		buckets_seen = 0;
	end

	// zero acts as one, anything past 2^HASH_BITS saturates
	function automatic logic [63:0] table_modulus(input logic [CFG_DATA_W-1:0] cap);
		logic [63:0] m;
		m = {32'd0, cap};
		if (m == 64'd0)
			m = 64'd1;
		if (m > (64'd1 << HASH_BITS))
			m = 64'd1 << HASH_BITS;
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [63:0]          m;
		logic [HASH_BITS-1:0] want;
		if (!arst_n) begin
			capacity_reg   = CAPACITY_RESET;
			multiplier_reg = MULTIPLIER_RESET;
			hash_acc       = 64'd0;
			bucket_q.delete();
			outstanding   <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_CAPACITY: begin
						capacity_reg = cfg_data;
					end
					REG_MULTIPLIER: begin
						multiplier_reg = cfg_data;
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				m = table_modulus(capacity_reg);
				// byte folds in before the finish step when both are set
				if (has_byte)
					hash_acc = (hash_acc * multiplier_reg + key_byte) % m;
				if (last_byte) begin
					bucket_q.push_back(HASH_BITS'((hash_acc * 2 + 1) % m));
					hash_acc = 64'd0;
				end
			end
			if (out_valid && !out_stall) begin
				buckets_seen++;
				if (bucket_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: bucket %0d arrived with none pending", $realtime, bucket);
				end else begin
					want = bucket_q.pop_front();
					if (bucket !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: bucket wrong: expected %0d, got %0d",
								$realtime, want, bucket);
					end
				end
			end
			outstanding <= bucket_q.size();
		end
	end

endmodule

/* test/polynomial_string_hash_mod_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_string_hash_mod_test
// Drives keys byte by byte into the string hash: a directed run over empty
// keys, byteless beats, register extremes and a modulus change inside a key,
// then random keys under random settings with three idling patterns.
// ----------------------------------------------------------------------------
module polynomial_string_hash_mod_test;
	import pshm_pkg::*;

	localparam int HASH_BITS    = 31;
	localparam int SETTLE       = 2 * HASH_BITS + 40;
	localparam int LIMIT        = 1_000_000;
	localparam int RANDOM_ITEMS = 650;
	localparam int SEGMENTS     = 12;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_CAPACITY;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic [BYTE_W-1:0]      key_byte  = '0;
	logic                   has_byte  = 1'b0;
	logic                   last_byte = 1'b0;
	logic                   out_stall = 1'b0;
	logic                   in_stall;
	logic                   out_valid;
	logic [HASH_BITS-1:0]   bucket;

	int errors;
	int outstanding;
	int buckets_seen;
	int send_idle_pct  = 13;
	int recv_idle_pct  = 52;
	int beats_sent     = 0;
	int settings_used  = 0;
	int cycle_count    = 0;

	always #5 clk = ~clk;

	polynomial_string_hash_mod #(
		.HASH_BITS(HASH_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key_byte(key_byte),
		.has_byte(has_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bucket(bucket)
	);

	polynomial_string_hash_mod_check #(
		.HASH_BITS(HASH_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key_byte(key_byte),
		.has_byte(has_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bucket(bucket),
		.errors(errors),
		.outstanding(outstanding),
		.buckets_seen(buckets_seen)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("polynomial_string_hash_mod: mismatch");
			$finish;
		end
	end

	// valid is left high on return so back-to-back beats need no second drive
	task automatic send_beat(input logic [BYTE_W-1:0] b, input logic has, input logic fin);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		key_byte  <= b;
		has_byte  <= has;
		last_byte <= fin;
		do
			@(posedge clk);
		while (in_stall);
		if (has || fin)
			beats_sent++;
	endtask

	// hold off until every bucket is back, then let any byte beat finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] cap, input logic [CFG_DATA_W-1:0] mul);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= REG_CAPACITY;
		cfg_data  <= cap;
		@(posedge clk);
		cfg_index <= REG_MULTIPLIER;
		cfg_data  <= mul;
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_capacity();
		case ($urandom_range(6))
			0: return 32'd0;
			1: return 32'd1;
			2: return $urandom_range(2, 300);
			3: return $urandom;
			4: return 32'h8000_0000;
			5: return 32'h8000_0000 | $urandom;
			default: return $urandom_range(301, 100000);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_multiplier();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd31;
			3: return 32'hFFFF_FFFF;
			4: return $urandom_range(2, 1000);
			default: return $urandom;
		endcase
	endfunction

	// a well-formed key, now and then with ignored beats mixed in
	task automatic send_key();
		int len;
		bit byteless_end;
		len = $urandom_range(0, 7);
		byteless_end = (len == 0) || ($urandom_range(99) < 20);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 5)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, !byteless_end && i == len - 1);
		end
		if (byteless_end)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: capacity 1024, multiplier 31
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b1);
		send_beat(8'h80, 1'b1, 1'b0);
		send_beat(8'h7F, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h41, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'h42, 1'b1, 1'b1);

		// saturated capacity, key left open across the next write
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		set_config(32'd0, 32'hFFFF_FFFF);
		send_beat(8'h01, 1'b1, 1'b1);
		send_beat(8'h00, 1'b0, 1'b1);

		// stored hash above the new, smaller modulus
		set_config(32'h8000_0000, 32'd0);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hC3, 1'b1, 1'b0);
		set_config(32'd7, 32'h8000_0001);
		send_beat(8'h5A, 1'b1, 1'b1);
		set_config(32'd1, 32'd1);
		send_beat(8'h11, 1'b1, 1'b1);
		set_config(32'h7FFF_FFFF, 32'hDEAD_BEEF);
		send_beat(8'h01, 1'b1, 1'b0);
		send_beat(8'hFE, 1'b1, 1'b1);

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 52 : 0;
			recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 13 : 0;
			for (int seg = 0; seg < SEGMENTS / 3; seg++) begin
				set_config(pick_capacity(), pick_multiplier());
				target = beats_sent + RANDOM_ITEMS / SEGMENTS;
				while (beats_sent < target)
					send_key();
				// leave a key half done now and then
				if ($urandom_range(1))
					send_beat(8'($urandom), 1'b1, 1'b0);
			end
		end
		send_beat(8'($urandom), 1'b1, 1'b1);
		drain();

		$display("%0d key beats over %0d register settings, %0d buckets checked",
			beats_sent, settings_used, buckets_seen);
		$display("covered empty keys, ignored beats, zero and saturated capacity, mid-key writes");
		if (errors == 0 && outstanding == 0)
			$display("polynomial_string_hash_mod: match");
		else
			$display("polynomial_string_hash_mod: mismatch");
		$finish;
	end

endmodule

/* files.f */
sv/pshm_pkg.sv
sv/pshm_datapath.sv
sv/pshm_ctrl.sv
sv/polynomial_string_hash_mod.sv
test/polynomial_string_hash_mod_check.sv
test/polynomial_string_hash_mod_test.sv
